[rtl/next_prime_search_top_assert.svh]
// Assertion macros for the next prime search RTL.
// Depends on nothing; included by next_prime_search_top.sv to check its own logic.
`ifndef NEXT_PRIME_SEARCH_TOP_ASSERT_SVH
`define NEXT_PRIME_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication under reset.
`define NPS_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication under reset.
`define NPS_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`endif

[rtl/nps_pkg.sv]
// Constants and types for the next prime search block.
// Depends on nothing; used by nps_rem_unit and next_prime_search_top.
`default_nettype none

package nps_pkg;

    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int DIV_W = 16;
    localparam int SQ_W = 32;
    localparam int OUT_W = 31;
    localparam logic [DIV_W-1:0] DIVISOR_LIMIT = 16'd46341;
    localparam logic [DIV_W-1:0] FIRST_DIVISOR = 16'd2;
    localparam logic [SQ_W-1:0] FIRST_SQUARE = 32'd4;
    localparam logic [OUT_W-1:0] SMALLEST_PRIME = 31'd2;

    typedef struct packed {
        logic done;
        logic zero;
    } rem_status_t;

endpackage

`default_nettype wire

[rtl/nps_rem_unit.sv]
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on nps_pkg for the divisor width and the status word type.
`default_nettype none

module nps_rem_unit #(
    parameter int VALUE_BITS = nps_pkg::VALUE_BITS_DEFAULT
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire [VALUE_BITS-2:0]         dividend,
    input  wire [nps_pkg::DIV_W-1:0]     divisor,
    output nps_pkg::rem_status_t         status
);

    localparam int W = VALUE_BITS - 1;
    localparam int CNT_W = $clog2(W + 1);
    localparam int D = nps_pkg::DIV_W;

    logic             active_reg;
    logic             active_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [W-1:0]     shift_reg;
    logic [W-1:0]     shift_next;
    logic [D-1:0]     rem_reg;
    logic [D-1:0]     rem_next;
    logic [D-1:0]     divisor_reg;
    logic [D-1:0]     divisor_next;
    logic [D:0]       trial;
    logic [D:0]       diff;

    always_comb
    begin
        trial = {rem_reg, shift_reg[W-1]};
        diff = trial - {1'b0, divisor_reg};
        active_next = active_reg;
        done_next = 1'b0;
        count_next = count_reg;
        shift_next = shift_reg;
        rem_next = rem_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            active_next = 1'b1;
            count_next = CNT_W'(W);
            shift_next = dividend;
            rem_next = '0;
            divisor_next = divisor;
        end
        else if (active_reg)
        begin
            shift_next = {shift_reg[W-2:0], 1'b0};
            rem_next = (trial >= {1'b0, divisor_reg}) ? diff[D-1:0] : trial[D-1:0];
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                active_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign status.done = done_reg;
    assign status.zero = (rem_reg == '0);

endmodule

`default_nettype wire

[rtl/next_prime_search_top.sv]
// Top level of the next prime search: sequencer, candidate and divisor registers.
// Depends on nps_pkg, nps_rem_unit and next_prime_search_top_assert.svh.
//
// Usage: drive start_value and raise start while busy is low; that word is
// taken at the clock edge. busy stays high until the search ends. The result
// appears on prime_found with done high for exactly one cycle; the receiver
// cannot hold it off, and a new word may be started in that same cycle.
// Start values below 2, negative ones included, answer 2 in the cycle after
// the start without going busy. Otherwise each candidate is tested by trial
// division with divisors from 2 while the divisor squared is at most the
// candidate and the divisor is below 46341. Each divisor test runs through
// the bit-serial remainder unit, and the search goes on over the candidates
// up to the next prime. The count-up stops at 2^(VALUE_BITS-1) - 1, which is
// returned as found. Reset clears the sequencer and the strobe; no clearing
// pass is needed and the block is ready right after reset.
`default_nettype none
`include "next_prime_search_top_assert.svh"

module next_prime_search_top #(
    parameter int VALUE_BITS = nps_pkg::VALUE_BITS_DEFAULT
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    input  wire signed [VALUE_BITS-1:0]      start_value,
    output logic                             busy,
    output logic                             done,
    output logic [nps_pkg::OUT_W-1:0]        prime_found
);

    localparam int VB = VALUE_BITS;
    localparam int D = nps_pkg::DIV_W;
    localparam int SQ = nps_pkg::SQ_W;
    localparam int OW = nps_pkg::OUT_W;
    localparam int CW = (VB > SQ) ? VB : SQ;
    localparam int EW = (VB > OW) ? VB : OW;
    localparam logic [VB-1:0] CEIL = {1'b0, {(VB-1){1'b1}}};

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CHECK  = 2'd1;
    localparam logic [1:0] ST_TEST   = 2'd2;
    localparam logic [1:0] ST_DIVIDE = 2'd3;

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic          done_reg;
    logic          done_next;
    logic [VB-1:0] cand_reg;
    logic [VB-1:0] cand_next;
    logic [D-1:0]  d_reg;
    logic [D-1:0]  d_next;
    logic [SQ-1:0] dsq_reg;
    logic [SQ-1:0] dsq_next;
    logic [OW-1:0] out_reg;
    logic [OW-1:0] out_next;

    logic [VB-1:0] start_u;
    logic [EW-1:0] cand_ext;
    logic [CW-1:0] cand_cmp;
    logic [CW-1:0] dsq_cmp;
    logic          accept;
    logic          rem_start;
    nps_pkg::rem_status_t rem_status;

    nps_rem_unit #(
        .VALUE_BITS(VALUE_BITS)
    ) u_rem (
        .clk(clk),
        .rst_n(rst_n),
        .start(rem_start),
        .dividend(cand_reg[VB-2:0]),
        .divisor(d_reg),
        .status(rem_status)
    );

    always_comb
    begin
        start_u = start_value;
        cand_ext = EW'(cand_reg);
        cand_cmp = CW'(cand_reg);
        dsq_cmp = CW'(dsq_reg);
        accept = start && (state_reg == ST_IDLE);
        rem_start = 1'b0;
        state_next = state_reg;
        done_next = 1'b0;
        cand_next = cand_reg;
        d_next = d_reg;
        dsq_next = dsq_reg;
        out_next = out_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (start_u[VB-1] || (start_u < VB'(2)))
                    begin
                        out_next = nps_pkg::SMALLEST_PRIME;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        cand_next = start_u;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (cand_reg >= CEIL)
                begin
                    out_next = cand_ext[OW-1:0];
                    done_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    d_next = nps_pkg::FIRST_DIVISOR;
                    dsq_next = nps_pkg::FIRST_SQUARE;
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if ((d_reg < nps_pkg::DIVISOR_LIMIT) && (dsq_cmp <= cand_cmp))
                begin
                    rem_start = 1'b1;
                    state_next = ST_DIVIDE;
                end
                else
                begin
                    out_next = cand_ext[OW-1:0];
                    done_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE:
            begin
                if (rem_status.done)
                begin
                    if (rem_status.zero)
                    begin
                        cand_next = cand_reg + VB'(1);
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        d_next = d_reg + D'(1);
                        dsq_next = dsq_reg + SQ'({d_reg, 1'b1});
                        state_next = ST_TEST;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        d_reg <= d_next;
        dsq_reg <= dsq_next;
        out_reg <= out_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign prime_found = out_reg;

    `NPS_ASSERT_IMPLY(a_result_at_least_two, clk, rst_n, done_reg, out_reg >= nps_pkg::SMALLEST_PRIME)
    `NPS_ASSERT_NEXT(a_accept_answers_or_works, clk, rst_n, accept, busy || done_reg)
    `NPS_ASSERT_IMPLY(a_divisor_in_range, clk, rst_n, state_reg == ST_DIVIDE, (d_reg >= nps_pkg::FIRST_DIVISOR) && (d_reg < nps_pkg::DIVISOR_LIMIT))
    `NPS_ASSERT_IMPLY(a_unit_done_only_dividing, clk, rst_n, rem_status.done, state_reg == ST_DIVIDE)

endmodule

`default_nettype wire

[test/tb_next_prime_search_top.sv]
// Self-checking testbench for next_prime_search_top: start words are sent
// through the start/busy handshake and each done strobe is compared with a predicted prime.
// Depends on nps_pkg and the RTL of next_prime_search_top.
`timescale 1ns / 100ps

module tb_next_prime_search_top;

    localparam int VALUE_BITS = nps_pkg::VALUE_BITS_DEFAULT;
    localparam int OUT_W = nps_pkg::OUT_W;
    localparam longint unsigned TRIAL_BOUND = 46341;
    localparam longint unsigned LOWEST_PRIME = 2;
    localparam logic [VALUE_BITS-1:0] VALUE_CEILING = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] MOST_NEGATIVE = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam int RANDOM_WORDS = 80;

    typedef struct {
        logic signed [VALUE_BITS-1:0] start_value;
        logic [OUT_W-1:0]             prime;
    } prime_check_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic signed [VALUE_BITS-1:0] start_value;
    logic                         busy;
    logic                         done;
    logic [OUT_W-1:0]             prime_found;

    prime_check_t    pending_primes[$];
    int              error_count;
    bit              no_idle;
    longint unsigned cycle_count;
    longint unsigned cycle_budget;

    next_prime_search_top #(
        .VALUE_BITS(VALUE_BITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .start_value(start_value),
        .busy(busy),
        .done(done),
        .prime_found(prime_found)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [OUT_W-1:0] next_prime_of(
        input logic signed [VALUE_BITS-1:0] value,
        output longint unsigned trials
    );
        longint unsigned v;
        longint unsigned cand;
        longint unsigned d;
        longint unsigned ceiling;
        bit composite;
        bit searching;
        trials = 0;
        v = 0;
        v[VALUE_BITS-1:0] = value;
        ceiling = (64'd1 << (VALUE_BITS - 1)) - 1;
        if (v[VALUE_BITS-1] || v < LOWEST_PRIME)
        begin
            return OUT_W'(LOWEST_PRIME);
        end
        cand = v;
        searching = 1'b1;
        while (searching && cand < ceiling)
        begin
            composite = 1'b0;
            d = 2;
            trials += 2;
            while (!composite && d < TRIAL_BOUND && d * d <= cand)
            begin
                trials++;
                if (cand % d == 0)
                begin
                    composite = 1'b1;
                end
                else
                begin
                    d++;
                end
            end
            if (composite)
            begin
                cand++;
            end
            else
            begin
                searching = 1'b0;
            end
        end
        return cand[OUT_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic send_word(input logic signed [VALUE_BITS-1:0] value);
        int gap;
        longint unsigned trials;
        prime_check_t expected;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        expected.start_value = value;
        expected.prime = next_prime_of(value, trials);
        cycle_budget += trials * (VALUE_BITS + 1) * 4 + 400;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        start_value <= value;
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_primes.push_back(expected);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_primes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word prime_found=%0d", prime_found));
            end
            else
            begin
                if (prime_found !== pending_primes[0].prime)
                begin
                    report_mismatch($sformatf("start_value=%0d prime_found=%0d expected %0d",
                        pending_primes[0].start_value, prime_found, pending_primes[0].prime));
                end
                void'(pending_primes.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > cycle_budget)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic test_low_extremes();
        no_idle = 1'b0;
        send_word(MOST_NEGATIVE);
        send_word(-1);
        send_word(0);
        send_word(1);
        no_idle = 1'b1;
        send_word(2);
        send_word(3);
        send_word(0);
        send_word(1024);
        no_idle = 1'b0;
        send_word(65537);
    endtask

    task automatic test_prime_squares();
        no_idle = 1'b0;
        send_word(4);
        send_word(8);
        send_word(9);
        send_word(24);
        send_word(25);
        no_idle = 1'b1;
        send_word(48);
        send_word(49);
        send_word(120);
        send_word(121);
        no_idle = 1'b0;
        send_word(169);
        send_word(289);
        send_word(961);
    endtask

    task automatic test_search_ceiling();
        no_idle = 1'b0;
        send_word(VALUE_CEILING - 1);
        send_word(VALUE_CEILING);
    endtask

    task automatic test_random_words();
        logic signed [VALUE_BITS-1:0] value;
        logic [OUT_W-1:0] root;
        longint unsigned trials;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 16 == 0)
            begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    value = $urandom;
                    value[VALUE_BITS-1] = 1'b1;
                end
                2: value = $urandom_range(0, 3);
                3, 4, 5, 6, 7: value = $urandom_range(4, 2000);
                8: value = $urandom_range(2001, 200000);
                default:
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        value = VALUE_CEILING - $urandom_range(0, 1);
                    end
                    else
                    begin
                        root = next_prime_of($urandom_range(2, 200), trials);
                        value = VALUE_BITS'(root * root);
                    end
                end
            endcase
            send_word(value);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        start_value = '0;
        error_count = 0;
        no_idle = 1'b0;
        cycle_count = 0;
        cycle_budget = 20000;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_low_extremes();
        test_prime_squares();
        test_search_ceiling();
        test_random_words();
        start <= 1'b0;
        while (pending_primes.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (error_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[next_prime_search_top.f]
+incdir+rtl
rtl/nps_pkg.sv
rtl/nps_rem_unit.sv
rtl/next_prime_search_top.sv
test/tb_next_prime_search_top.sv
